// ===== src/cel_pkg.sv =====
// Shared constants and types of the Canny edge line pipeline.
`default_nettype none
package cel_pkg;

	localparam int DEF_MAX_WIDTH = 1024;

	localparam logic [10:0] RST_WIDTH  = 11'd640;
	localparam logic [11:0] RST_HEIGHT = 12'd480;
	localparam logic [10:0] RST_LOW    = 11'd50;
	localparam logic [10:0] RST_HIGH   = 11'd150;

	localparam logic [14:0] TAN_22_5_Q16 = 15'd27146;

	localparam int MAG_W  = 21;
	localparam int GRAD_W = 23;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_LOW    = 2'd2,
		REG_HIGH   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		SEC_HOR  = 2'd0,
		SEC_FALL = 2'd1,
		SEC_VER  = 2'd2,
		SEC_RISE = 2'd3
	} sector_t;

	typedef enum logic [1:0] {
		CLS_NONE   = 2'd0,
		CLS_WEAK   = 2'd1,
		CLS_STRONG = 2'd2
	} edge_cls_t;

	typedef struct packed {
		logic emit;
		logic last;
	} tag_t;

endpackage
`default_nettype wire

// ===== src/canny_edge_line_pipeline.sv =====
// Top level of the Canny edge line pipeline: blur, Sobel, suppression and thresholds.
`default_nettype none
// The block takes one 8-bit grey pixel per clock in raster order and returns one edge class
// for every pixel at least three away from each border, with frame_last on the last one of a
// frame. Each result passes stages s1 to s5 and the output register, and while the output is not
// stalled one pixel per clock is sustained; a stall on the result side holds the whole pipeline.
// Three line stores of MAX_WIDTH entries (raw, blurred and gradient rows, each entry holding
// two rows) take one read and one write per cycle. The user must write image sizes and thresholds
// through the register port only while no pixel is in flight; the block does not enforce this.
module canny_edge_line_pipeline #(
	parameter int MAX_WIDTH = cel_pkg::DEF_MAX_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [3:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	input  wire logic                  pixel_valid,
	output logic                       pixel_ready,
	input  wire logic [7:0]            pixel,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output logic      [1:0]            edge_class,
	output logic                       frame_last
);
	import cel_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic [10:0] width_q;
	logic [11:0] height_q;
	logic [10:0] low_q;
	logic [10:0] high_q;
	logic [21:0] low_sq_q;
	logic [21:0] high_sq_q;

	logic [WW-1:0] w_eff;
	logic [11:0]   h_eff;
	logic [CW-1:0] col_q;
	logic [11:0]   row_q;
	logic          col_end;
	logic          row_end;
	logic          en;
	logic          accept;

	logic          v_s1, v_s2, v_s3, v_s4, v_s5;
	tag_t          tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic [CW-1:0] col_s1, col_s2, col_s3, col_s4;
	logic [7:0]    px_s1;

	logic [15:0]       raw_mem [MAX_WIDTH];
	logic [15:0]       raw_rd_q;
	logic [7:0]        raw_win_q [3][3];
	logic [15:0]       blur_mem [MAX_WIDTH];
	logic [15:0]       blur_rd_q;
	logic [7:0]        blur_win_q [3][3];
	logic [2*GRAD_W-1:0] grad_mem [MAX_WIDTH];
	logic [2*GRAD_W-1:0] grad_rd_q;
	logic [GRAD_W-1:0] grad_win_q [3][3];

	logic [12:0] blur_sum;
	logic [7:0]  blur_px;
	logic [9:0]  gx_pos, gx_neg, gy_pos, gy_neg;
	logic signed [11:0] gx_s4, gy_s4;
	logic [9:0]  ax, ay;
	logic [19:0] ax2, ay2;
	logic [25:0] ax_t, ay_t;
	logic [MAG_W-1:0] mag;
	sector_t     sector;
	logic [GRAD_W-1:0] grad_px;

	logic [MAG_W-1:0] cur, n1, n2;
	edge_cls_t   cls;

	// Register port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			low_q    <= RST_LOW;
			high_q   <= RST_HIGH;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_WIDTH:  width_q  <= pwdata[10:0];
				REG_HEIGHT: height_q <= pwdata[11:0];
				REG_LOW:    low_q    <= pwdata[10:0];
				REG_HIGH:   high_q   <= pwdata[10:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			REG_LOW:    prdata = 32'(low_q);
			REG_HIGH:   prdata = 32'(high_q);
		endcase
	end

	always_ff @(posedge clk) begin
		low_sq_q  <= low_q * low_q;
		high_sq_q <= high_q * high_q;
	end

	// Frame position.
	always_comb begin
		if (width_q < 11'd8)
			w_eff = WW'(8);
		else if (32'(width_q) > MAX_WIDTH)
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(width_q);
		h_eff = (height_q < 12'd8) ? 12'd8 : height_q;
	end

	assign col_end     = (32'(col_q) + 32'd1) >= 32'(w_eff);
	assign row_end     = (32'(row_q) + 32'd1) >= 32'(h_eff);
	assign en          = !result_valid || result_ready;
	assign pixel_ready = en;
	assign accept      = pixel_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? 12'd0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			result_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= pixel_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			result_valid <= v_s5 && tag_s5.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1       <= pixel;
			col_s1      <= col_q;
			tag_s1.emit <= (row_q >= 12'd6) && (32'(col_q) >= 32'd6);
			tag_s1.last <= col_end && row_end;
			col_s2 <= col_s1;
			col_s3 <= col_s2;
			col_s4 <= col_s3;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	// Raw rows: entry holds {upper row, middle row}.
	always_ff @(posedge clk) begin
		if (en)
			raw_rd_q <= raw_mem[col_q];
		if (en && v_s1)
			raw_mem[col_s1] <= {raw_rd_q[7:0], px_s1};
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			for (int i = 0; i < 3; i++) begin
				raw_win_q[i][0] <= raw_win_q[i][1];
				raw_win_q[i][1] <= raw_win_q[i][2];
			end
			raw_win_q[0][2] <= raw_rd_q[15:8];
			raw_win_q[1][2] <= raw_rd_q[7:0];
			raw_win_q[2][2] <= px_s1;
		end
	end

	// Blur.
	always_comb begin
		blur_sum = 13'(raw_win_q[0][0]) + 13'({raw_win_q[0][1], 1'b0}) + 13'(raw_win_q[0][2])
			+ 13'({raw_win_q[1][0], 1'b0}) + 13'({raw_win_q[1][1], 2'b0})
			+ 13'({raw_win_q[1][2], 1'b0})
			+ 13'(raw_win_q[2][0]) + 13'({raw_win_q[2][1], 1'b0}) + 13'(raw_win_q[2][2])
			+ 13'd8;
		blur_px = blur_sum[11:4];
	end

	always_ff @(posedge clk) begin
		if (en)
			blur_rd_q <= blur_mem[col_s1 - CW'(1)];
		if (en && v_s2 && (col_s2 != '0))
			blur_mem[col_s2 - CW'(1)] <= {blur_rd_q[7:0], blur_px};
	end

	always_ff @(posedge clk) begin
		if (en && v_s2 && (col_s2 != '0)) begin
			for (int i = 0; i < 3; i++) begin
				blur_win_q[i][0] <= blur_win_q[i][1];
				blur_win_q[i][1] <= blur_win_q[i][2];
			end
			blur_win_q[0][2] <= blur_rd_q[15:8];
			blur_win_q[1][2] <= blur_rd_q[7:0];
			blur_win_q[2][2] <= blur_px;
		end
	end

	// Sobel.
	always_comb begin
		gx_pos = 10'(blur_win_q[0][2]) + 10'({blur_win_q[1][2], 1'b0}) + 10'(blur_win_q[2][2]);
		gx_neg = 10'(blur_win_q[0][0]) + 10'({blur_win_q[1][0], 1'b0}) + 10'(blur_win_q[2][0]);
		gy_pos = 10'(blur_win_q[2][0]) + 10'({blur_win_q[2][1], 1'b0}) + 10'(blur_win_q[2][2]);
		gy_neg = 10'(blur_win_q[0][0]) + 10'({blur_win_q[0][1], 1'b0}) + 10'(blur_win_q[0][2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s4 <= $signed({2'b00, gx_pos}) - $signed({2'b00, gx_neg});
			gy_s4 <= $signed({2'b00, gy_pos}) - $signed({2'b00, gy_neg});
		end
	end

	// Magnitude and direction sector.
	always_comb begin
		ax   = gx_s4[11] ? 10'(-gx_s4) : 10'(gx_s4);
		ay   = gy_s4[11] ? 10'(-gy_s4) : 10'(gy_s4);
		ax2  = ax * ax;
		ay2  = ay * ay;
		ax_t = ax * TAN_22_5_Q16;
		ay_t = ay * TAN_22_5_Q16;
		mag  = {1'b0, ax2} + {1'b0, ay2};
		priority if ({ay, 16'b0} <= ax_t)
			sector = SEC_HOR;
		else if ({ax, 16'b0} < ay_t)
			sector = SEC_VER;
		else if (gx_s4[11] == gy_s4[11])
			sector = SEC_FALL;
		else
			sector = SEC_RISE;
		grad_px = {sector, mag};
	end

	always_ff @(posedge clk) begin
		if (en)
			grad_rd_q <= grad_mem[col_s3 - CW'(2)];
		if (en && v_s4 && (32'(col_s4) >= 32'd2))
			grad_mem[col_s4 - CW'(2)] <= {grad_rd_q[GRAD_W-1:0], grad_px};
	end

	always_ff @(posedge clk) begin
		if (en && v_s4 && (32'(col_s4) >= 32'd2)) begin
			for (int i = 0; i < 3; i++) begin
				grad_win_q[i][0] <= grad_win_q[i][1];
				grad_win_q[i][1] <= grad_win_q[i][2];
			end
			grad_win_q[0][2] <= grad_rd_q[2*GRAD_W-1:GRAD_W];
			grad_win_q[1][2] <= grad_rd_q[GRAD_W-1:0];
			grad_win_q[2][2] <= grad_px;
		end
	end

	// Non-maximum suppression and thresholds.
	always_comb begin
		cur = grad_win_q[1][1][MAG_W-1:0];
		unique case (sector_t'(grad_win_q[1][1][GRAD_W-1:MAG_W]))
			SEC_HOR: begin
				n1 = grad_win_q[1][0][MAG_W-1:0];
				n2 = grad_win_q[1][2][MAG_W-1:0];
			end
			SEC_FALL: begin
				n1 = grad_win_q[0][0][MAG_W-1:0];
				n2 = grad_win_q[2][2][MAG_W-1:0];
			end
			SEC_VER: begin
				n1 = grad_win_q[0][1][MAG_W-1:0];
				n2 = grad_win_q[2][1][MAG_W-1:0];
			end
			SEC_RISE: begin
				n1 = grad_win_q[0][2][MAG_W-1:0];
				n2 = grad_win_q[2][0][MAG_W-1:0];
			end
		endcase
		cls = CLS_NONE;
		if (cur > n1 && cur > n2) begin
			priority if ({1'b0, cur} > high_sq_q)
				cls = CLS_STRONG;
			else if ({1'b0, cur} > low_sq_q)
				cls = CLS_WEAK;
			else
				cls = CLS_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			edge_class <= cls;
			frame_last <= tag_s5.last;
		end
	end

	a_class_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (edge_class == CLS_NONE || edge_class == CLS_WEAK
			|| edge_class == CLS_STRONG))
		else $error("edge class out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !en) |=> (v_s5 && $stable(tag_s5)))
		else $error("last stage lost its pixel during a stall");

	a_ready_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> (result_valid && !result_ready))
		else $error("input blocked without an output stall");

endmodule
`default_nettype wire
